[rtl/core/apc_pkg.sv]
// Shared constants, field widths and the Adams coefficient table for the
// predictor-corrector block. Depends on nothing; used by every module in rtl/core.
package apc_pkg;

    localparam int DATA_W       = 32;
    localparam int STEP_W       = 31;
    localparam int INDEX_W      = 6;
    localparam int ORDER_W      = 3;
    localparam int RING         = 4;
    localparam int NUM_VARS_DEF = 64;

    // Weighted sum: coefficient numerators over 24 times Q16.16 derivatives.
    localparam int COEF_W = 7;
    localparam int TERM_W = DATA_W + COEF_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int MAG_W  = TERM_W;

    // Radix-4 serial multiply of the sum magnitude by the timestep.
    localparam int MUL_DIGITS = (STEP_W + 1) / 2;
    localparam int MUL_W      = MAG_W + 2 * MUL_DIGITS;
    localparam int FRAC_W     = 16;
    localparam int T_W        = MUL_W - FRAC_W;

    // Rounded division by 24: add half, drop three bits, radix-4 divide by 3.
    localparam int ROUND_BIAS = 12;
    localparam int QUO_W      = T_W - 3;
    localparam int DIV_DIGITS = QUO_W / 2;
    localparam int RES_W      = QUO_W + 2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    localparam logic CFG_PREDICT_ORDER = 1'b0;
    localparam logic CFG_CORRECT_ORDER = 1'b1;

    // Numerators over 24 of the Adams-Bashforth (predict) and Adams-Moulton
    // (correct) weights; term 0 is the newest derivative.
    function automatic logic signed [COEF_W-1:0] coef(
        input logic               is_corr,
        input logic [ORDER_W-1:0] ord,
        input logic [1:0]         term
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        unique case ({is_corr, ord, term})
            {1'b0, 3'd2, 2'd0}: c = 7'sd24;
            {1'b0, 3'd3, 2'd0}: c = 7'sd36;
            {1'b0, 3'd3, 2'd1}: c = -7'sd12;
            {1'b0, 3'd4, 2'd0}: c = 7'sd46;
            {1'b0, 3'd4, 2'd1}: c = -7'sd32;
            {1'b0, 3'd4, 2'd2}: c = 7'sd10;
            {1'b0, 3'd5, 2'd0}: c = 7'sd55;
            {1'b0, 3'd5, 2'd1}: c = -7'sd59;
            {1'b0, 3'd5, 2'd2}: c = 7'sd37;
            {1'b0, 3'd5, 2'd3}: c = -7'sd9;
            {1'b1, 3'd3, 2'd0}: c = 7'sd12;
            {1'b1, 3'd3, 2'd1}: c = 7'sd12;
            {1'b1, 3'd4, 2'd0}: c = 7'sd10;
            {1'b1, 3'd4, 2'd1}: c = 7'sd16;
            {1'b1, 3'd4, 2'd2}: c = -7'sd2;
            {1'b1, 3'd5, 2'd0}: c = 7'sd9;
            {1'b1, 3'd5, 2'd1}: c = 7'sd19;
            {1'b1, 3'd5, 2'd2}: c = -7'sd5;
            {1'b1, 3'd5, 2'd3}: c = 7'sd1;
            default:            c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/adams_predictor_corrector.sv]
// Top level of the Adams-Bashforth / Adams-Moulton predictor-corrector.
// Uses apc_pkg, apc_store, apc_mul and apc_div.
//
// Each request concerns one state variable. A predict request (op 0) stores
// the variable's present value and, in the history ring, its derivative f(t),
// and returns the value plus timestep times the Adams-Bashforth weighted sum
// of recent derivatives. A correct request (op 1) carries f(t+1) and returns
// the stored value plus timestep times the Adams-Moulton weighted sum; with
// integrated low it returns the stored f(t) instead. A correct request with
// end_of_step high rotates the history ring and advances the step counter
// that ramps the orders up over the first steps. All values are signed
// Q16.16, the timestep unsigned Q15.16, and results round to nearest (ties
// away from zero) and saturate. The block works on one request at a time:
// one weighted term (one to four) at a time on a single small-coefficient
// multiply-accumulate, then it takes the magnitude, runs the radix-4 serial
// timestep multiplier and the serial divide by 24, and rounds, adds and
// saturates. A non-integrated correct request skips these steps. A finished
// result sits in an output register, so the next request is taken while it
// waits. After reset the block zeroes its memories and takes no request in
// that time; configuration writes are taken at any time the block is idle.
module adams_predictor_corrector #(
    parameter int NUM_VARS = apc_pkg::NUM_VARS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [apc_pkg::ORDER_W-1:0]     cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [apc_pkg::INDEX_W-1:0]     var_index,
    input  logic signed [apc_pkg::DATA_W-1:0] present_value,
    input  logic signed [apc_pkg::DATA_W-1:0] slope,
    input  logic [apc_pkg::STEP_W-1:0]      step_size,
    input  logic                            integrated,
    input  logic                            end_of_step,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [apc_pkg::INDEX_W-1:0]     out_index,
    output logic signed [apc_pkg::DATA_W-1:0] new_value,
    output logic                            was_correct
);

    localparam int ADDR_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int DW     = apc_pkg::DATA_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Configuration and step bookkeeping.
    logic [apc_pkg::ORDER_W-1:0] predict_order_reg;
    logic [apc_pkg::ORDER_W-1:0] correct_order_reg;
    logic [1:0]                  cursor_reg;
    logic [1:0]                  steps_reg;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Request captured at acceptance.
    logic                           op_item;
    logic [apc_pkg::INDEX_W-1:0]    index_item;
    logic [DW-1:0]                  value_item;
    logic [DW-1:0]                  first_item;
    logic [apc_pkg::STEP_W-1:0]     step_item;
    logic                           bypass_item;
    logic                           in_range_item;
    logic [1:0]                     cursor_item;
    logic [apc_pkg::ORDER_W-1:0]    order_item;
    logic [1:0]                     last_item;

    logic [1:0]                      term_reg;
    logic signed [apc_pkg::SUM_W-1:0] acc_reg;

    logic out_valid_reg;
    logic [apc_pkg::INDEX_W-1:0] out_index_reg;
    logic [DW-1:0]               new_value_reg;
    logic                        was_correct_reg;

    logic                        accept;
    logic                        in_range;
    logic [ADDR_W+apc_pkg::INDEX_W-1:0] index_wide;
    logic [ADDR_W-1:0]           addr;
    logic                        clear_busy;
    logic [apc_pkg::RING-1:0][DW-1:0] hist_q;
    logic [DW-1:0]               saved_q;

    logic [apc_pkg::ORDER_W-1:0] p_clamp;
    logic [apc_pkg::ORDER_W-1:0] c_clamp;
    logic [apc_pkg::ORDER_W-1:0] p_limit;
    logic [apc_pkg::ORDER_W-1:0] c_limit;
    logic [apc_pkg::ORDER_W-1:0] order_sel;

    logic [1:0]                  hist_off;
    logic [1:0]                  hist_slot;
    logic [DW-1:0]               term_val;
    logic signed [apc_pkg::COEF_W-1:0] term_coef;
    logic signed [apc_pkg::TERM_W-1:0] term_prod;

    logic                        acc_neg;
    logic [apc_pkg::SUM_W-1:0]   acc_abs;
    logic                        mul_start;
    logic                        mul_done;
    logic [apc_pkg::T_W-1:0]     scaled;
    logic                        div_start;
    logic                        div_done;
    logic [apc_pkg::QUO_W-1:0]   quotient;

    logic [DW-1:0]               base;
    logic signed [apc_pkg::RES_W-1:0] base_ext;
    logic signed [apc_pkg::RES_W-1:0] quo_ext;
    logic signed [apc_pkg::RES_W-1:0] raw_sum;
    logic [DW-1:0]               sat_value;
    logic [DW-1:0]               result;
    logic                        out_load;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE) && !clear_busy;
    assign in_range   = 32'(var_index) < 32'(NUM_VARS);
    assign index_wide = {{ADDR_W{1'b0}}, var_index};
    assign addr       = index_wide[ADDR_W-1:0];

    apc_store #(
        .NUM_VARS (NUM_VARS),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .wr_en      (accept && (op == apc_pkg::OP_PREDICT) && in_range),
        .addr       (addr),
        .cursor     (cursor_reg),
        .slope_in   (slope),
        .value_in   (present_value),
        .hist_q     (hist_q),
        .saved_q    (saved_q),
        .clear_busy (clear_busy)
    );

    // Effective orders: clamp the registers, then limit by steps taken so far.
    always_comb
    begin
        p_clamp = (predict_order_reg < 3'd2) ? 3'd2 :
                  (predict_order_reg > 3'd5) ? 3'd5 : predict_order_reg;
        c_clamp = (correct_order_reg < 3'd3) ? 3'd3 :
                  (correct_order_reg > 3'd5) ? 3'd5 : correct_order_reg;
        p_limit = {1'b0, steps_reg} + 3'd2;
        c_limit = {1'b0, steps_reg} + 3'd3;
        if (op == apc_pkg::OP_PREDICT)
        begin
            order_sel = (p_clamp > p_limit) ? p_limit : p_clamp;
        end
        else
        begin
            order_sel = (c_clamp > c_limit) ? c_limit : c_clamp;
        end
    end

    // Term 0 is the newest derivative from the request itself. Later terms
    // come from the ring; a predict has already put f(t) in slot zero, so
    // its history offset is one ahead of a correct's.
    always_comb
    begin
        hist_off  = (op_item == apc_pkg::OP_CORRECT) ? term_reg - 2'd1 : term_reg;
        hist_slot = cursor_item + hist_off;
        if (term_reg == 2'd0)
        begin
            term_val = first_item;
        end
        else
        begin
            term_val = in_range_item ? hist_q[hist_slot] : '0;
        end
        term_coef = apc_pkg::coef(op_item, order_item, term_reg);
        term_prod = $signed({{(apc_pkg::TERM_W - apc_pkg::COEF_W){term_coef[apc_pkg::COEF_W-1]}},
                             term_coef})
                  * $signed({{(apc_pkg::TERM_W - DW){term_val[DW-1]}}, term_val});
    end

    assign acc_neg   = acc_reg[apc_pkg::SUM_W-1];
    assign acc_abs   = acc_neg ? -acc_reg : acc_reg;
    assign mul_start = (state_reg == S_MAG);
    assign div_start = (state_reg == S_MUL) && mul_done;

    apc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mag    (acc_abs[apc_pkg::MAG_W-1:0]),
        .step   (step_item),
        .done   (mul_done),
        .scaled (scaled)
    );

    apc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled),
        .done     (div_done),
        .quotient (quotient)
    );

    // Final add of the rounded increment to the base value, with saturation; a bypassed correct takes the stored f(t).
    always_comb
    begin
        if (op_item == apc_pkg::OP_CORRECT)
        begin
            base = in_range_item ? saved_q : '0;
        end
        else
        begin
            base = value_item;
        end
        base_ext = $signed({{(apc_pkg::RES_W - DW){base[DW-1]}}, base});
        quo_ext  = $signed({2'b00, quotient});
        raw_sum  = acc_neg ? base_ext - quo_ext : base_ext + quo_ext;
        if (raw_sum[apc_pkg::RES_W-1:DW-1] == '0 || raw_sum[apc_pkg::RES_W-1:DW-1] == '1)
        begin
            sat_value = raw_sum[DW-1:0];
        end
        else if (raw_sum[apc_pkg::RES_W-1])
        begin
            sat_value = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(DW-1){1'b1}}};
        end
        if (bypass_item)
        begin
            result = in_range_item ? hist_q[cursor_item] : '0;
        end
        else
        begin
            result = sat_value;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op == apc_pkg::OP_CORRECT) && !integrated)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (term_reg == last_item)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predict_order_reg <= 3'd3;
            correct_order_reg <= 3'd5;
            cursor_reg        <= 2'd0;
            steps_reg         <= 2'd0;
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    apc_pkg::CFG_PREDICT_ORDER: predict_order_reg <= cfg_data;
                    apc_pkg::CFG_CORRECT_ORDER: correct_order_reg <= cfg_data;
                    default:                    predict_order_reg <= predict_order_reg;
                endcase
            end

            // The ring turns back one slot so the newest derivative of the
            // next step lands in a fresh slot and older ones age by one.
            if (accept && (op == apc_pkg::OP_CORRECT) && end_of_step)
            begin
                cursor_reg <= cursor_reg - 2'd1;
                if (steps_reg != 2'd3)
                begin
                    steps_reg <= steps_reg + 2'd1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_item       <= op;
            index_item    <= var_index;
            value_item    <= in_range ? present_value : '0;
            first_item    <= (in_range || (op == apc_pkg::OP_CORRECT)) ? slope : '0;
            step_item     <= step_size;
            bypass_item   <= (op == apc_pkg::OP_CORRECT) && !integrated;
            in_range_item <= in_range;
            cursor_item   <= cursor_reg;
            order_item    <= order_sel;
            last_item     <= 2'(order_sel - 3'd2);
            term_reg      <= 2'd0;
            acc_reg       <= '0;
        end
        else if (state_reg == S_SUM)
        begin
            term_reg <= term_reg + 2'd1;
            acc_reg  <= acc_reg + {{(apc_pkg::SUM_W - apc_pkg::TERM_W){term_prod[apc_pkg::TERM_W-1]}},
                                   term_prod};
        end

        if (out_load)
        begin
            out_index_reg   <= index_item;
            new_value_reg   <= result;
            was_correct_reg <= op_item;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign new_value   = new_value_reg;
    assign was_correct = was_correct_reg;

endmodule

[rtl/core/apc_store.sv]
// Derivative history banks (one per ring slot) and saved state values, with
// the zeroing pass after reset. Depends on apc_pkg.
module apc_store #(
    parameter int NUM_VARS = apc_pkg::NUM_VARS_DEF,
    parameter int ADDR_W   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            rd_en,
    input  logic                                            wr_en,
    input  logic [ADDR_W-1:0]                               addr,
    input  logic [1:0]                                      cursor,
    input  logic [apc_pkg::DATA_W-1:0]                      slope_in,
    input  logic [apc_pkg::DATA_W-1:0]                      value_in,
    output logic [apc_pkg::RING-1:0][apc_pkg::DATA_W-1:0]   hist_q,
    output logic [apc_pkg::DATA_W-1:0]                      saved_q,
    output logic                                            clear_busy
);

    logic              clear_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] wr_addr;

    logic [apc_pkg::DATA_W-1:0] saved_mem [NUM_VARS];
    logic [apc_pkg::DATA_W-1:0] saved_q_reg;

    assign clear_busy = clear_reg;
    assign wr_addr    = clear_reg ? clr_cnt_reg : addr;
    assign saved_q    = saved_q_reg;

    // Zero every entry once after reset, one address per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clr_cnt_reg == ADDR_W'(NUM_VARS - 1))
            begin
                clear_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg || wr_en)
        begin
            saved_mem[wr_addr] <= clear_reg ? '0 : value_in;
        end
        if (rd_en)
        begin
            saved_q_reg <= saved_mem[addr];
        end
    end

    for (genvar b = 0; b < apc_pkg::RING; b++)
    begin : g_bank
        logic [apc_pkg::DATA_W-1:0] mem [NUM_VARS];
        logic [apc_pkg::DATA_W-1:0] rd_reg;
        logic                       we;

        assign we        = clear_reg || (wr_en && (cursor == 2'(b)));
        assign hist_q[b] = rd_reg;

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[wr_addr] <= clear_reg ? '0 : slope_in;
            end
            if (rd_en)
            begin
                rd_reg <= mem[addr];
            end
        end
    end

endmodule

[rtl/core/apc_mul.sv]
// Radix-4 serial multiplier: sum magnitude times timestep, two timestep bits
// per cycle, product shifted right through one register. Depends on apc_pkg.
module apc_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [apc_pkg::MAG_W-1:0]     mag,
    input  logic [apc_pkg::STEP_W-1:0]    step,
    output logic                          done,
    output logic [apc_pkg::T_W-1:0]       scaled
);

    localparam int CNT_W = $clog2(apc_pkg::MUL_DIGITS);
    localparam int LO_W  = 2 * apc_pkg::MUL_DIGITS;
    localparam int ADD_W = apc_pkg::MAG_W + 2;

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [apc_pkg::MAG_W-1:0]   mag_reg;
    logic [ADD_W-1:0]            mag3_reg;
    logic [apc_pkg::MUL_W-1:0]   prod_reg;
    logic [apc_pkg::MUL_W-1:0]   prod_next;
    logic [ADD_W-1:0]            addend;
    logic [ADD_W-1:0]            partial;

    always_comb
    begin
        unique case (prod_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, mag_reg};
            2'd2:    addend = {1'b0, mag_reg, 1'b0};
            default: addend = mag3_reg;
        endcase
        partial   = {2'b00, prod_reg[apc_pkg::MUL_W-1:LO_W]} + addend;
        prod_next = {partial, prod_reg[LO_W-1:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(apc_pkg::MUL_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= mag;
            mag3_reg <= {2'b00, mag} + {1'b0, mag, 1'b0};
            prod_reg <= {{(apc_pkg::MUL_W - apc_pkg::STEP_W){1'b0}}, step};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done   = done_reg;
    assign scaled = prod_reg[apc_pkg::MUL_W-1:apc_pkg::FRAC_W];

endmodule

[rtl/core/apc_div.sv]
// Rounded division by 24: adds half a divisor, drops three bits, then divides
// by 3 two bits per cycle with a two-bit remainder. Depends on apc_pkg.
module apc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [apc_pkg::T_W-1:0]       dividend,
    output logic                          done,
    output logic [apc_pkg::QUO_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(apc_pkg::DIV_DIGITS);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [apc_pkg::QUO_W-1:0]    quo_reg;
    logic [1:0]                   rem_reg;
    logic [apc_pkg::T_W-1:0]      biased;
    logic [3:0]                   window;
    logic [1:0]                   digit;
    logic [3:0]                   rem_full;

    assign biased = dividend + apc_pkg::T_W'(apc_pkg::ROUND_BIAS);
    assign window = {rem_reg, quo_reg[apc_pkg::QUO_W-1 -: 2]};

    always_comb
    begin
        priority if (window >= 4'd9)
        begin
            digit = 2'd3;
        end
        else if (window >= 4'd6)
        begin
            digit = 2'd2;
        end
        else if (window >= 4'd3)
        begin
            digit = 2'd1;
        end
        else
        begin
            digit = 2'd0;
        end
        rem_full = window - {1'b0, digit, 1'b0} - {2'b00, digit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(apc_pkg::DIV_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= biased[apc_pkg::T_W-1:3];
            rem_reg <= 2'b00;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[apc_pkg::QUO_W-3:0], digit};
            rem_reg <= rem_full[1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
